// ----- rtl/tted_pkg.sv -----
`timescale 1ns / 1ps
package tted_pkg;
    localparam int NUM_TIMERS = 16;
    localparam int IDX_W = 4;
    localparam int TIME_W = 64;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  slot;
        logic              prev;
        logic              rep;
        logic [TIME_W-1:0] cmp;
        logic [TIME_W-1:0] tmo;
        logic              last;
    } res_t;
endpackage

// ----- rtl/timer_table_earliest_deadline_top.sv -----
`timescale 1ns / 1ps
// Sixteen-slot timer compare unit. In the back end each word is loaded, the
// slot table is scanned one slot at a time, the scan is closed, and the FIN
// and OUT states finish the status word (FIN first emits an expired event for
// a SET already due); an expired event stalls the scan while the previous result
// word still waits on m_tready. A two-word queue decouples the input.
module timer_table_earliest_deadline_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // due_time, current_time
    input  logic [5:0]   s_tuser,  // command, timer_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // event_timer, previous_state, reprogram,
                                   // compare_due, timeout, pad
    output logic         m_tuser,  // result_kind
    output logic         m_tlast
);
    import tted_pkg::*;

    logic  q_valid, q_ready;
    cmd_t  q_data;
    res_t  r;

    tted_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_cmd(s_tuser[1:0]), .s_idx(s_tuser[5:2]),
        .s_due(s_tdata[63:0]), .s_now(s_tdata[127:64]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    tted_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
    );

    assign m_tuser = r.kind;
    assign m_tlast = r.last;
    assign m_tdata = {2'b00, r.tmo, r.cmp, r.rep, r.prev, r.slot};
endmodule

// ----- rtl/tted_front.sv -----
`timescale 1ns / 1ps
module tted_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     s_cmd,
    input  logic [3:0]     s_idx,
    input  logic [63:0]    s_due,
    input  logic [63:0]    s_now,
    output logic           q_valid,
    input  logic           q_ready,
    output tted_pkg::cmd_t q_data
);
    import tted_pkg::*;

    // two-entry queue; due time resolved to absolute on entry
    cmd_t             mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    cmd_t             w;
    logic             nz;
    logic [TIME_W:0]  sum;
    logic [TIME_W-1:0] mag;

    always_comb begin
        nz  = (s_due == 64'd0) || s_due[63];
        mag = TIME_W'(64'd0 - s_due);
        sum = {1'b0, s_now[TIME_W-1:0]} + {1'b0, mag};
        w.cmd = s_cmd;
        w.idx = s_idx;
        w.now = s_now[TIME_W-1:0];
        if (nz) begin
            w.due = (sum[TIME_W] || ((64'd0 - s_due) > 64'(TIME_MAX))) ? TIME_MAX
                                                                     : sum[TIME_W-1:0];
        end else begin
            w.due = (s_due > 64'(TIME_MAX)) ? TIME_MAX : s_due[TIME_W-1:0];
        end
    end

    assign s_tready = cnt_reg != 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mem_reg[wp_reg] <= w;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(s_tvalid && s_tready) - 2'(q_valid && q_ready);
        end
    end
endmodule

// ----- rtl/tted_back.sv -----
`timescale 1ns / 1ps
module tted_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  tted_pkg::cmd_t q_data,
    output logic           r_valid,
    input  logic           r_ready,
    output tted_pkg::res_t r_data
);
    import tted_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]        state_reg, state_next;
    cmd_t              c_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [TIME_W-1:0] due_mem [NUM_TIMERS];
    logic [TIME_W-1:0] gdue_reg;
    logic [TIME_W-1:0] earl_reg;
    logic [TIME_W-1:0] d_reg;
    logic [IDX_W:0]    i_reg;
    logic              prev_reg;
    logic              fire_reg;
    res_t              out_reg;
    res_t              out_next;
    logic              ov_reg;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  i_inc;
    logic              scan_end;
    logic              hit;
    logic              set_rep;
    logic              out_load;
    logic              emit_free;

    assign i = i_reg[IDX_W-1:0];
    assign i_inc = i + 1'b1;
    assign scan_end = (i_reg == (IDX_W+1)'(NUM_TIMERS));
    assign hit = (c_reg.cmd == CMD_TICK) && armed_reg[i] && (d_reg <= c_reg.now);
    assign set_rep = (c_reg.due < earl_reg) && (c_reg.due < gdue_reg);
    assign r_valid = ov_reg;
    assign r_data = out_reg;
    assign emit_free = !ov_reg || r_ready;
    assign q_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_SCAN;
            ST_SCAN: if (scan_end && emit_free) state_next = ST_FIN;
            ST_FIN:  if (emit_free) state_next = ST_OUT;
            ST_OUT:  if (emit_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        out_next = '{KIND_STATUS, '0, 1'b0, 1'b0, '0, '0, 1'b1};
        unique case (state_reg)
            ST_SCAN: begin
                out_load      = emit_free && !scan_end && hit;
                out_next.kind = KIND_EXPIRED;
                out_next.slot = i;
                out_next.last = 1'b0;
            end
            ST_FIN: begin
                out_load      = emit_free && (c_reg.cmd == CMD_SET) && fire_reg;
                out_next.kind = KIND_EXPIRED;
                out_next.slot = c_reg.idx;
                out_next.last = 1'b0;
            end
            ST_OUT: begin
                out_load = emit_free;
                unique case (c_reg.cmd)
                    CMD_SET: begin
                        out_next.slot = c_reg.idx;
                        out_next.prev = prev_reg;
                        if (!fire_reg && set_rep) begin
                            out_next.rep = 1'b1;
                            out_next.cmp = c_reg.due;
                            out_next.tmo = c_reg.due - c_reg.now;
                        end
                    end
                    CMD_CANCEL: begin
                        out_next.slot = c_reg.idx;
                        out_next.prev = prev_reg;
                    end
                    CMD_TICK: begin
                        if (earl_reg != TIME_MAX) begin
                            out_next.rep = 1'b1;
                            out_next.cmp = earl_reg;
                            out_next.tmo = earl_reg - c_reg.now;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_load) out_reg <= out_next;
        if (state_reg == ST_IDLE && q_valid) begin
            c_reg    <= q_data;
            earl_reg <= TIME_MAX;
            d_reg    <= due_mem[0];
            prev_reg <= (q_data.cmd == CMD_SET || q_data.cmd == CMD_CANCEL) ?
                        armed_reg[q_data.idx] : 1'b0;
            fire_reg <= (q_data.cmd == CMD_SET) && (q_data.due <= q_data.now);
            if (q_data.cmd == CMD_SET) due_mem[q_data.idx] <= q_data.due;
        end
        if (state_reg == ST_SCAN && !scan_end) begin
            if (!hit && armed_reg[i] && d_reg < earl_reg) earl_reg <= d_reg;
            if (!hit || emit_free) d_reg <= due_mem[i_inc];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            armed_reg <= '0;
            gdue_reg  <= TIME_MAX;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                ov_reg <= 1'b1;
            end else if (r_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (q_valid) begin
                    i_reg <= '0;
                    if (q_data.cmd == CMD_TICK) gdue_reg <= TIME_MAX;
                    if (q_data.cmd == CMD_SET || q_data.cmd == CMD_CANCEL) begin
                        armed_reg[q_data.idx] <= 1'b0;
                    end
                end
                ST_SCAN: if (!scan_end && (!hit || emit_free)) begin
                    if (hit) armed_reg[i] <= 1'b0;
                    i_reg <= i_reg + 1'b1;
                end
                ST_OUT: if (emit_free) begin
                    if (c_reg.cmd == CMD_SET && !fire_reg) begin
                        armed_reg[c_reg.idx] <= 1'b1;
                        if (set_rep) gdue_reg <= c_reg.due;
                    end else if (c_reg.cmd == CMD_TICK && earl_reg != TIME_MAX) begin
                        gdue_reg <= earl_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
